>>> rtl/crc_checked_word_deframer_top_macros.svh
// Assertion macros for the word deframer
`ifndef CRC_CHECKED_WORD_DEFRAMER_TOP_MACROS_SVH
`define CRC_CHECKED_WORD_DEFRAMER_TOP_MACROS_SVH

// check cons in the same cycle as ante
`define CRCWD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// check cons in the cycle after ante
`define CRCWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

>>> rtl/crcwd_pkg.sv
package crcwd_pkg;

    localparam logic [7:0] CRC_INIT          = 8'hFF;
    localparam logic [7:0] CRC_POLY          = 8'h31;
    localparam logic [2:0] MAX_WORDS         = 3'd6;
    localparam logic [2:0] FRAME_WORDS_RESET = 3'd6;

    typedef enum logic [1:0] {
        PH_HIGH = 2'd0,
        PH_LOW  = 2'd1,
        PH_CRC  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } rx_item_t;

    typedef struct packed {
        logic [15:0] word_value;
        logic        crc_match;
        logic [2:0]  word_index;
        logic [31:0] pair_value;
        logic        pair_valid;
        logic        frame_end;
        logic        frame_crc_ok;
    } result_t;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [2:0] eff_words(input logic [2:0] n);
        logic [2:0] w;
        w = n;
        if (n == 3'd0)
        begin
            w = 3'd1;
        end
        else if (n > MAX_WORDS)
        begin
            w = MAX_WORDS;
        end
        return w;
    endfunction

endpackage

>>> rtl/crcwd_if.sv
interface crcwd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface crcwd_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] word_value;
    logic        crc_match;
    logic [2:0]  word_index;
    logic [31:0] pair_value;
    logic        pair_valid;
    logic        frame_end;
    logic        frame_crc_ok;

    modport source (
        output valid, output word_value, output crc_match, output word_index,
        output pair_value, output pair_valid, output frame_end, output frame_crc_ok,
        input ready
    );
    modport sink (
        input valid, input word_value, input crc_match, input word_index,
        input pair_value, input pair_valid, input frame_end, input frame_crc_ok,
        output ready
    );
endinterface

>>> rtl/crcwd_in_stage.sv
module crcwd_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    crcwd_byte_if.sink          rx_chan,
    output logic                s1_valid,
    output crcwd_pkg::rx_item_t s1_item,
    input  logic                core_ready
);
    import crcwd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    rx_item_t item_reg;
    logic     take;

    assign rx_chan.ready = !valid_reg || core_ready;
    assign take          = rx_chan.valid && rx_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (core_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // hold payload until the core takes it
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.rx_byte     <= rx_chan.rx_byte;
            item_reg.frame_start <= rx_chan.frame_start;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

>>> rtl/crcwd_core.sv
module crcwd_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_wdata,
    input  logic                s1_valid,
    input  crcwd_pkg::rx_item_t s1_item,
    output logic                core_ready,
    crcwd_word_if.source        word_chan
);
    import crcwd_pkg::*;

    phase_t      phase_reg,    phase_next;
    logic [2:0]  pos_reg,      pos_next;
    logic        ok_reg,       ok_next;
    logic [7:0]  high_reg,     high_next;
    logic [7:0]  low_reg,      low_next;
    logic [7:0]  crc_reg,      crc_next;
    logic [15:0] prev_reg,     prev_next;
    logic [2:0]  words_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg,      res_next;

    phase_t      phase_eff;
    logic [2:0]  pos_eff;
    logic        ok_eff;
    logic        out_free;
    logic        take;
    logic [15:0] word;
    logic        match;
    logic        last;

    assign phase_eff  = s1_item.frame_start ? PH_HIGH : phase_reg;
    assign pos_eff    = s1_item.frame_start ? 3'd0 : pos_reg;
    assign ok_eff     = s1_item.frame_start ? 1'b1 : ok_reg;
    assign out_free   = !out_valid_reg || word_chan.ready;
    assign core_ready = (phase_eff != PH_CRC) || out_free;
    assign take       = s1_valid && core_ready;

    assign word  = {high_reg, low_reg};
    assign match = (crc_reg == s1_item.rx_byte);
    assign last  = ({1'b0, pos_eff} + 4'd1) >= {1'b0, eff_words(words_reg)};

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        ok_next        = ok_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        crc_next       = crc_reg;
        prev_next      = prev_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !word_chan.ready;
        if (take)
        begin
            pos_next = pos_eff;
            ok_next  = ok_eff;
            unique case (phase_eff)
                PH_HIGH:
                begin
                    high_next  = s1_item.rx_byte;
                    crc_next   = crc_step(CRC_INIT, s1_item.rx_byte);
                    phase_next = PH_LOW;
                end
                PH_LOW:
                begin
                    low_next   = s1_item.rx_byte;
                    crc_next   = crc_step(crc_reg, s1_item.rx_byte);
                    phase_next = PH_CRC;
                end
                default:
                begin
                    phase_next            = PH_HIGH;
                    res_next.word_value   = word;
                    res_next.crc_match    = match;
                    res_next.word_index   = pos_eff;
                    res_next.pair_valid   = pos_eff[0];
                    res_next.pair_value   = pos_eff[0] ? {prev_reg, word} : 32'd0;
                    res_next.frame_end    = last;
                    res_next.frame_crc_ok = ok_eff && match;
                    out_valid_next        = 1'b1;
                    prev_next             = word;
                    if (last)
                    begin
                        pos_next = 3'd0;
                        ok_next  = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_eff + 3'd1;
                        ok_next  = ok_eff && match;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HIGH;
            pos_reg       <= 3'd0;
            ok_reg        <= 1'b1;
            high_reg      <= 8'd0;
            low_reg       <= 8'd0;
            crc_reg       <= 8'd0;
            prev_reg      <= 16'd0;
            words_reg     <= FRAME_WORDS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            ok_reg        <= ok_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            crc_reg       <= crc_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                words_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign word_chan.valid        = out_valid_reg;
    assign word_chan.word_value   = res_reg.word_value;
    assign word_chan.crc_match    = res_reg.crc_match;
    assign word_chan.word_index   = res_reg.word_index;
    assign word_chan.pair_value   = res_reg.pair_value;
    assign word_chan.pair_valid   = res_reg.pair_valid;
    assign word_chan.frame_end    = res_reg.frame_end;
    assign word_chan.frame_crc_ok = res_reg.frame_crc_ok;

endmodule

>>> rtl/crc_checked_word_deframer_top.sv
// The third byte of a word passes the input register, then the result register.
// Throughput: 1 byte per cycle; the input and result registers keep the byte stream
// moving while a result waits, but a word's third byte waits for the output to free.
// Reset (rst_n low, asynchronous): byte position and word index go to 0, frame ok to 1,
// frame length to 6 words, both pipeline registers empty.
`include "crc_checked_word_deframer_top_macros.svh"

module crc_checked_word_deframer_top (
    input  logic         clk,
    input  logic         rst_n,
    crcwd_byte_if.sink   rx_chan,
    crcwd_word_if.source word_chan,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_wdata
);
    import crcwd_pkg::*;

    logic     s1_valid;
    rx_item_t s1_item;
    logic     core_ready;

    crcwd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_chan    (rx_chan),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item),
        .core_ready (core_ready)
    );

    crcwd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item),
        .core_ready (core_ready),
        .word_chan  (word_chan)
    );

    `CRCWD_ASSERT_SAME(a_pair_odd, clk, rst_n, word_chan.valid, word_chan.pair_valid == word_chan.word_index[0])
    `CRCWD_ASSERT_SAME(a_pair_zero, clk, rst_n, word_chan.valid && !word_chan.pair_valid, word_chan.pair_value == 32'd0)
    `CRCWD_ASSERT_SAME(a_bad_crc, clk, rst_n, word_chan.valid && !word_chan.crc_match, !word_chan.frame_crc_ok)
    `CRCWD_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid && !core_ready, s1_valid && $stable(s1_item))

endmodule
